// File: rtl/olrb_pkg.sv
// olrb_pkg: shared types and constants of the overwriting log ring buffer
// depends on nothing; used by overwriting_log_ring_buffer_unit

package olrb_pkg;

   localparam int DEFAULT_DEPTH = 1024;
   localparam int BYTE_W        = 8;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REWIND = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic [BYTE_W-1:0]  data_in;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_out;
      logic               data_valid;
      logic               dropped_oldest;
   } rsp_type;

endpackage

// File: rtl/olrb_ram.sv
// olrb_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing

module olrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/overwriting_log_ring_buffer_unit.sv
// overwriting_log_ring_buffer_unit: top level of the overwriting byte log ring buffer
// depends on olrb_pkg and olrb_ram
//
// usage
//   a transaction is taken at a rising edge with start high and busy low; req_item
//   carries the command (write, pop, rewind, cursor read) and the byte to write.
//   every transaction gives exactly one result on rsp_item, shown for one cycle
//   with rsp_strobe high; the receiver cannot stall and must take it then.
//   the store holds at most DEPTH-1 bytes; a write to a full buffer drops the
//   oldest byte (dropped_oldest) and drags the reader cursor along if it sat there.
// result path and busy
//   write, rewind and reads on an empty buffer: the result is registered at the
//   accepting edge, and the next transaction may follow in the next cycle.
//   pop and cursor read with data: the byte passes the ram's read register and
//   then the result register; busy is high for one cycle while the byte comes out
//   of the ram's registered read port, and no transaction is taken while busy.
// reset
//   synchronous reset empties the buffer (all pointers to zero); ram contents
//   are left as they are and no clearing pass runs.

module overwriting_log_ring_buffer_unit #(
   parameter int DEPTH = olrb_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  olrb_pkg::req_type req_item,
   output logic              rsp_strobe,
   output olrb_pkg::rsp_type rsp_item
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);

   typedef enum logic {
      S_IDLE,
      S_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [ADDR_W-1:0] oldest_ff, oldest_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic              strobe_ff, strobe_in;
   olrb_pkg::rsp_type rsp_ff, rsp_in;

   logic                       accept;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_raddr;
   logic [olrb_pkg::BYTE_W-1:0] ram_rdata;
   logic [ADDR_W-1:0]          wp_next;
   logic [ADDR_W-1:0]          oldest_next;
   logic [ADDR_W-1:0]          cursor_next;

   function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   assign busy        = (state_ff == S_WAIT);
   assign accept      = start && !busy;
   assign wp_next     = next_slot(wp_ff);
   assign oldest_next = next_slot(oldest_ff);
   assign cursor_next = next_slot(cursor_ff);
   assign ram_we      = accept && (req_item.command == olrb_pkg::CMD_WRITE);
   assign ram_raddr   = (req_item.command == olrb_pkg::CMD_POP) ? oldest_ff : cursor_ff;

   olrb_ram #(
      .WIDTH (olrb_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (req_item.data_in),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      oldest_in = oldest_ff;
      cursor_in = cursor_ff;
      strobe_in = 1'b0;
      rsp_in    = '0;
      unique case (state_ff)
         S_WAIT: begin
            strobe_in          = 1'b1;
            rsp_in.data_out    = ram_rdata;
            rsp_in.data_valid  = 1'b1;
            state_in           = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_item.command)
                  olrb_pkg::CMD_WRITE: begin
                     strobe_in = 1'b1;
                     if (wp_next == oldest_ff) begin
                        rsp_in.dropped_oldest = 1'b1;
                        oldest_in             = oldest_next;
                        if (cursor_ff == oldest_ff) begin
                           cursor_in = oldest_next;
                        end
                     end
                     wp_in = wp_next;
                  end
                  olrb_pkg::CMD_POP: begin
                     if (wp_ff != oldest_ff) begin
                        oldest_in = oldest_next;
                        state_in  = S_WAIT;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
                  olrb_pkg::CMD_REWIND: begin
                     strobe_in = 1'b1;
                     cursor_in = oldest_ff;
                  end
                  olrb_pkg::CMD_READ: begin
                     if (wp_ff != cursor_ff) begin
                        cursor_in = cursor_next;
                        state_in  = S_WAIT;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wp_ff     <= '0;
         oldest_ff <= '0;
         cursor_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         oldest_ff <= oldest_in;
         cursor_ff <= cursor_in;
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // a read with data holds busy while the ram answers, and no result shows then
   assert property (@(posedge clock) disable iff (reset) busy |-> !rsp_strobe)
      else $error("result strobe during ram wait");

   // every transaction gives a result now or after the ram wait
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy))
      else $error("transaction without result");

   assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe && rsp_item.data_valid)
      else $error("ram wait not followed by valid result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.data_valid) |-> (rsp_item.data_out == '0))
      else $error("nonzero data without valid");

   // a write never leaves the buffer looking empty
   assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (wp_ff != oldest_ff))
      else $error("write left buffer empty");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.dropped_oldest |-> !rsp_item.data_valid)
      else $error("drop flagged on a read");

endmodule
